/* rtl/fdc_pkg.sv */
// Shared types and constants for the FIFO block cache directory.
package fdc_pkg;

    localparam int unsigned TAG_W      = 24;
    localparam int unsigned SLOT_W     = 7;
    localparam int unsigned CAP_W      = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    localparam logic CMD_GET  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             command;
        logic [TAG_W-1:0] block_number;
    } fdc_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              fetch;
        logic              write_back;
        logic [TAG_W-1:0]  victim_block;
    } fdc_out_t;

    // One directory entry as kept in memory.
    typedef struct packed {
        logic             loaded;
        logic [TAG_W-1:0] tag;
    } fdc_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_FINISH
    } fdc_state_t;

endpackage

/* rtl/fdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fdc_ram #(
    parameter int unsigned WIDTH = 25,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/fifo_block_cache_directory_core.sv */
// Top level of the FIFO-replacement block buffer cache directory.
//
// Usage:
//   s_valid/s_ready/s_data carry one request (command, block_number).
//   m_valid/m_ready/m_data carry exactly one result per request (slot, hit,
//   fetch, write_back, victim_block). cfg_valid/cfg_ready/cfg_data write the
//   capacity register; cfg_ready is always high, write only while idle.
// Scan:
//   Tags and loaded flags sit in one RAM with a registered read. A request
//   scans the filled slots one per cycle through a two-stage read/compare
//   pipe. A hit ends the scan early; a miss with no free slot goes through
//   an eviction state that reads the victim entry. One request is in flight
//   at a time; s_ready is high only in the idle state.
// Stalls:
//   The result sits in an output register, so the next request is taken
//   while a result waits. A finished lookup holds in its last state until
//   that register is free, and only then updates the RAM.
// Reset:
//   Clears the fill count, the oldest pointer and the handshakes, and loads
//   the capacity register with 100. The RAM is not cleared: only slots
//   below the fill count are ever read.
module fifo_block_cache_directory_core #(
    parameter int unsigned SLOTS = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fdc_pkg::fdc_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fdc_pkg::fdc_out_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import fdc_pkg::*;

    localparam int unsigned AW    = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int unsigned ENT_W = TAG_W + 1;

    // Control state
    fdc_state_t       state_reg, state_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CNT_W-1:0] filled_reg, filled_next;
    logic [AW-1:0]    oldest_reg, oldest_next;
    logic [CNT_W-1:0] idx_reg, idx_next;        // next scan address to issue
    logic             cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             m_valid_reg, m_valid_next;

    // Request context (payload, no reset)
    logic             cmd_reg, cmd_next;
    logic [TAG_W-1:0] blk_reg, blk_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic             hit_reg, hit_next;
    logic             evict_reg, evict_next;
    logic             old_ld_reg, old_ld_next;
    logic [TAG_W-1:0] old_tag_reg, old_tag_next;
    fdc_out_t         out_reg, out_next;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    fdc_entry_t       ram_wdata, ram_rdata;

    // Decode helpers
    logic [CMP_W-1:0] cap_ext, eff_cap;
    logic             issue, match, scan_miss, has_room, out_free;
    logic [AW-1:0]    victim_idx;
    logic [CNT_W-1:0] victim_inc;
    logic             new_loaded, fetch_bit, wb_bit;

    fdc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // Capacity clamped into 1..SLOTS
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(SLOTS)) begin
            eff_cap = CMP_W'(SLOTS);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // Scan pipe: issue address idx, compare in the cycle after
    assign issue     = (idx_reg < filled_reg);
    assign match     = cmp_vld_reg && (ram_rdata.tag == blk_reg);
    assign scan_miss = !issue && !cmp_vld_reg;
    assign has_room  = (CMP_W'(filled_reg) < eff_cap);
    assign out_free  = !m_valid_reg || m_ready;

    // Oldest slot wrapped into the filled range, and its successor
    always_comb begin
        victim_idx = (CNT_W'(oldest_reg) >= filled_reg) ? '0 : oldest_reg;
        victim_inc = CNT_W'(victim_idx) + CNT_W'(1);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    state_next = ST_FINISH;
                end else if (scan_miss) begin
                    state_next = has_room ? ST_FINISH : ST_EVICT;
                end
            end
            ST_EVICT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result bits for the entry being finished
    always_comb begin
        if (hit_reg) begin
            fetch_bit  = (cmd_reg == CMD_READ) && !old_ld_reg;
            new_loaded = old_ld_reg || (cmd_reg == CMD_READ);
            wb_bit     = 1'b0;
        end else begin
            fetch_bit  = (cmd_reg == CMD_READ);
            new_loaded = (cmd_reg == CMD_READ);
            wb_bit     = evict_reg && old_ld_reg;
        end
    end

    // Datapath and outputs
    always_comb begin
        cap_next     = cap_reg;
        filled_next  = filled_reg;
        oldest_next  = oldest_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        m_valid_next = m_valid_reg;
        cmd_next     = cmd_reg;
        blk_next     = blk_reg;
        slot_next    = slot_reg;
        hit_next     = hit_reg;
        evict_next   = evict_reg;
        old_ld_next  = old_ld_reg;
        old_tag_next = old_tag_reg;
        out_next     = out_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = '{loaded: new_loaded, tag: blk_reg};
        ram_raddr    = idx_reg[AW-1:0];

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data.command;
                    blk_next = s_data.block_number;
                    idx_next = '0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    idx_next     = idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                end
                if (match) begin
                    slot_next   = cmp_idx_reg;
                    hit_next    = 1'b1;
                    evict_next  = 1'b0;
                    old_ld_next = ram_rdata.loaded;
                end else if (scan_miss) begin
                    hit_next    = 1'b0;
                    old_ld_next = 1'b0;
                    if (has_room) begin
                        slot_next   = filled_reg[AW-1:0];
                        filled_next = filled_reg + CNT_W'(1);
                        evict_next  = 1'b0;
                    end else begin
                        // Oldest-first eviction: read the victim entry
                        slot_next   = victim_idx;
                        ram_raddr   = victim_idx;
                        evict_next  = 1'b1;
                        oldest_next = (victim_inc >= filled_reg) ? '0
                                                                 : victim_inc[AW-1:0];
                    end
                end
            end
            ST_EVICT: begin
                old_ld_next  = ram_rdata.loaded;
                old_tag_next = ram_rdata.tag;
            end
            ST_FINISH: begin
                if (out_free) begin
                    ram_we                = 1'b1;
                    m_valid_next          = 1'b1;
                    out_next.slot         = SLOT_W'(slot_reg);
                    out_next.hit          = hit_reg;
                    out_next.fetch        = fetch_bit;
                    out_next.write_back   = wb_bit;
                    out_next.victim_block = wb_bit ? old_tag_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            filled_reg  <= '0;
            oldest_reg  <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            filled_reg  <= filled_next;
            oldest_reg  <= oldest_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
        cmp_idx_reg <= cmp_idx_next;
        cmd_reg     <= cmd_next;
        blk_reg     <= blk_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        evict_reg   <= evict_next;
        old_ld_reg  <= old_ld_next;
        old_tag_reg <= old_tag_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    // Fill count never passes the slot count
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(SLOTS))
        else $error("fill count above slot count");

    // Fill count only ever steps up by one
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (filled_reg != $past(filled_reg)) |->
        (filled_reg == $past(filled_reg) + CNT_W'(1)))
        else $error("fill count jumped");

    // A hit never reports a write-back
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.hit && out_reg.write_back))
        else $error("write-back flagged on a hit");

    // RAM is written only when a result is loaded into the output register
    a_we_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> m_valid_reg)
        else $error("directory update without a result");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the FIFO block cache directory core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdc_pkg::*;

    localparam int unsigned SLOTS       = 128;
    localparam int unsigned POOL_SIZE   = 64;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned TAIL        = 200;
    localparam int unsigned LIMIT       = 1000000;

    // DUT signals; every input starts at a known value
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    fdc_in_t     s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    fdc_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // Shadow copy of the directory, kept in step with accepted requests
    logic [TAG_W-1:0] dir_tags   [SLOTS];
    logic             dir_loaded [SLOTS];
    int unsigned      dir_oldest;
    int unsigned      dir_filled;
    logic [CAP_W-1:0] dir_capacity;

    // Results owed by the block, oldest first
    fdc_out_t pending_lookups[$];

    // Block numbers reused to get hits; entries 0 and 1 are the tag extremes
    logic [TAG_W-1:0] block_pool [POOL_SIZE];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    logic        rx_hold        = 1'b0;
    event        start_rx_hold;

    always #2 aclk = ~aclk;

    fifo_block_cache_directory_core #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result-side ready: random stalls, forced low during a hold-off
    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Long hold-off of the result side, counted here in cycles
    initial begin
        forever begin
            @(start_rx_hold);
            @(posedge aclk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Every result transfer is checked against the oldest owed result
    always @(posedge aclk) begin : check_result
        fdc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("unrequested result, slot", 32'(m_data.slot), '0);
            end else begin
                want = pending_lookups.pop_front();
                if (m_data.slot !== want.slot)
                    report_mismatch("slot", 32'(m_data.slot), 32'(want.slot));
                if (m_data.hit !== want.hit)
                    report_mismatch("hit", 32'(m_data.hit), 32'(want.hit));
                if (m_data.fetch !== want.fetch)
                    report_mismatch("fetch", 32'(m_data.fetch), 32'(want.fetch));
                if (m_data.write_back !== want.write_back)
                    report_mismatch("write_back", 32'(m_data.write_back),
                                    32'(want.write_back));
                if (m_data.victim_block !== want.victim_block)
                    report_mismatch("victim_block", 32'(m_data.victim_block),
                                    32'(want.victim_block));
            end
        end
    end

    // Directory lookup with FIFO replacement; updates the shadow state.
    function automatic fdc_out_t predict_lookup(fdc_in_t req);
        fdc_out_t    res;
        int unsigned cap;
        int unsigned s;
        bit          found;
        res   = '0;
        s     = 0;
        found = 1'b0;
        // capacity 0 behaves as 1, anything above the slot count as full size
        cap = 32'(dir_capacity);
        if (cap < 1)
            cap = 1;
        if (cap > SLOTS)
            cap = SLOTS;

        for (int unsigned i = 0; i < dir_filled; i++) begin
            if (!found && dir_tags[i] == req.block_number) begin
                s     = i;
                found = 1'b1;
            end
        end

        if (found) begin
            res.hit = 1'b1;
        end else if (dir_filled < cap) begin
            // free slot: appended above the filled ones
            s = dir_filled;
            dir_filled++;
            dir_tags[s]   = req.block_number;
            dir_loaded[s] = 1'b0;
        end else begin
            // full (or capacity lowered below fill): evict round the filled slots
            if (dir_oldest >= dir_filled)
                dir_oldest = 0;
            s = dir_oldest;
            if (dir_loaded[s]) begin
                res.write_back   = 1'b1;
                res.victim_block = dir_tags[s];
            end
            dir_tags[s]   = req.block_number;
            dir_loaded[s] = 1'b0;
            dir_oldest    = s + 1;
            if (dir_oldest >= dir_filled)
                dir_oldest = 0;
        end

        if (req.command == CMD_READ && !dir_loaded[s]) begin
            res.fetch     = 1'b1;
            dir_loaded[s] = 1'b1;
        end
        res.slot = SLOT_W'(s);
        return res;
    endfunction

    // One request transfer; valid stays high from one request to the next
    // unless an idle gap is drawn.
    task automatic issue_request(input logic cmd, input logic [TAG_W-1:0] blk);
        fdc_in_t req;
        req.command      = cmd;
        req.block_number = blk;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_lookups.push_back(predict_lookup(req));
    endtask

    // Drop valid, then wait until every owed result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Capacity register write; only called while the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        dir_capacity = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [TAG_W-1:0] pick_block(input int unsigned span);
        if ($urandom_range(0, 3) == 0)
            return TAG_W'($urandom);
        return block_pool[$urandom_range(0, span - 1)];
    endfunction

    // Capacity 0 acts as a single slot: hits, fetch on hit, eviction with
    // and without write-back, tag extremes.
    task automatic test_minimum_capacity();
        write_capacity(8'd0);
        issue_request(CMD_READ, 24'h000000);
        issue_request(CMD_READ, 24'h000000);
        issue_request(CMD_GET,  24'hFFFFFF);
        issue_request(CMD_READ, 24'hFFFFFF);
        issue_request(CMD_GET,  24'h123456);
        issue_request(CMD_GET,  24'h654321);
        wait_for_results();
    endtask

    // Capacity raised after eviction began: new slots go above the filled ones
    task automatic test_capacity_growth();
        write_capacity(8'd3);
        issue_request(CMD_READ, 24'hAAAAAA);
        issue_request(CMD_GET,  24'h555555);
        issue_request(CMD_READ, 24'h654321);
        issue_request(CMD_READ, 24'h000000);
        wait_for_results();
    endtask

    // Capacity lowered below the fill: counts as full, evicts round all filled
    task automatic test_capacity_shrink();
        write_capacity(8'd1);
        issue_request(CMD_GET,  24'h800000);
        issue_request(CMD_GET,  24'h000001);
        issue_request(CMD_READ, 24'h000000);
        wait_for_results();
    endtask

    // Values above the slot count clamp to the slot count
    task automatic test_capacity_clamp();
        write_capacity(8'd129);
        issue_request(CMD_READ, 24'h7FFFFF);
        wait_for_results();
        write_capacity(8'd255);
        issue_request(CMD_GET,  24'hFFFFFE);
        wait_for_results();
    endtask

    // Random traffic at one capacity; span sets how often blocks repeat
    task automatic test_random_traffic(input logic [CAP_W-1:0] capacity,
                                       input int unsigned span,
                                       input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
        write_capacity(capacity);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count)
            issue_request(1'($urandom_range(0, 1)), pick_block(span));
        wait_for_results();
    endtask

    // Result side held off while requests keep coming: input must stall
    task automatic test_output_backpressure(input int unsigned count);
        write_capacity(CAP_RESET);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        -> start_rx_hold;
        repeat (count)
            issue_request(1'($urandom_range(0, 1)), pick_block(POOL_SIZE));
        wait_for_results();
    endtask

    initial begin
        for (int unsigned i = 0; i < POOL_SIZE; i++)
            block_pool[i] = TAG_W'($urandom);
        block_pool[0] = '0;
        block_pool[1] = '1;
        dir_oldest    = 0;
        dir_filled    = 0;
        dir_capacity  = CAP_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_minimum_capacity();
        test_capacity_growth();
        test_capacity_shrink();
        test_capacity_clamp();

        // capacity, block span, sender idle %, receiver stall %, requests
        test_random_traffic(8'd6,   10,        0,  0,  100);
        test_random_traffic(8'd40,  48,        70, 0,  100);
        test_random_traffic(8'd255, POOL_SIZE, 0,  70, 110);
        test_random_traffic(8'd128, POOL_SIZE, 25, 25, 110);
        test_random_traffic(8'd20,  32,        0,  0,  100);
        test_output_backpressure(80);

        // anything arriving late is flagged as unrequested
        repeat (TAIL) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fdc_pkg.sv
rtl/fdc_ram.sv
rtl/fifo_block_cache_directory_core.sv
dv/testbench.sv
